>>> hdl/adcs_pkg.sv
// ----------------------------------------------------------------------------
// adcs_pkg: shared types and constants of the ADC scan averaging block
// Channel codes, scan phase codes, register indexes and the records passed
// between the scan stage and the scaling stages.
// ----------------------------------------------------------------------------
package adcs_pkg;

  // Width at which averages travel from the scan stage to the scaling stages.
  localparam int AVG_W  = 12;
  localparam int CH_W   = 3;
  localparam int REG_W  = 16;
  localparam int IDX_W  = 2;
  localparam int OUT_W  = 10;
  localparam int BUS_SHIFT = 10;

  // Channel numbers of the auxiliary scan.
  localparam logic [CH_W-1:0] CH_BUS = 3'd3;
  localparam logic [CH_W-1:0] CH_POT = 3'd4;
  localparam logic [CH_W-1:0] CH_AUX = 3'd6;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_BUS_GAIN    = 2'd0;
  localparam logic [IDX_W-1:0] REG_PWM_PERIOD  = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_DUTY    = 2'd2;
  localparam logic [IDX_W-1:0] REG_MAX_DUTY    = 2'd3;

  // Register values after reset.
  localparam logic [REG_W-1:0] RST_BUS_GAIN    = 16'd53;
  localparam logic [REG_W-1:0] RST_PWM_PERIOD  = 16'd6000;
  localparam logic [REG_W-1:0] RST_MIN_DUTY    = 16'd0;
  localparam logic [REG_W-1:0] RST_MAX_DUTY    = 16'd6000;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_BUS   = 4'b0010,
    PH_POT   = 4'b0100,
    PH_AUX   = 4'b1000
  } scan_phase_t;

  typedef struct packed {
    logic [REG_W-1:0] bus_gain;
    logic [REG_W-1:0] pwm_period;
    logic [REG_W-1:0] min_duty;
    logic [REG_W-1:0] max_duty;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  scanned_channel;
    logic [CH_W-1:0]  next_channel;
    logic [AVG_W-1:0] vbus_avg;
    logic [AVG_W-1:0] pot_avg;
    logic             vbus_updated;
    logic             pot_updated;
    logic [AVG_W-1:0] aux;
  } scan_rec_t;

  typedef struct packed {
    logic [CH_W-1:0]  scanned_channel;
    logic [CH_W-1:0]  next_channel;
    logic [OUT_W-1:0] vbus_average;
    logic [OUT_W-1:0] pot_average;
    logic             vbus_updated;
    logic             pot_updated;
    logic [REG_W-1:0] bus_voltage;
    logic [REG_W-1:0] pot_duty;
    logic [OUT_W-1:0] aux_sample;
  } result_t;

endpackage

>>> hdl/adc_scan_average_scale.sv
// ----------------------------------------------------------------------------
// adc_scan_average_scale: round-robin auxiliary ADC scan with block averages
// A result word is registered in turn by the scan, multiply and output
// registers after the edge that accepts its sample.
// Throughput: one sample word per cycle; while a finished result waits, new
// words are taken until the scan and multiply registers are full. Reset
// (synchronous) returns the scan to its start phase, clears sums and averages
// and loads the register defaults.
// ----------------------------------------------------------------------------
module adc_scan_average_scale #(
  parameter int VBUS_AVG_LOG2 = 6,
  parameter int POT_AVG_LOG2  = 3,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [9:0] sample_main
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] next_channel, [12:3] vbus_average, [22:13] pot_average,
  // [38:23] bus_voltage, [54:39] pot_duty, [64:55] aux_sample
  output logic [71:0] m_axis_tdata,
  // [2:0] scanned_channel, [3] vbus_updated, [4] pot_updated
  output logic [4:0]  m_axis_tuser,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  adcs_pkg::cfg_t      cfg;
  adcs_pkg::scan_rec_t rec;
  adcs_pkg::result_t   res;
  logic                rec_valid, rec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bus_gain    <= adcs_pkg::RST_BUS_GAIN;
      cfg.pwm_period  <= adcs_pkg::RST_PWM_PERIOD;
      cfg.min_duty    <= adcs_pkg::RST_MIN_DUTY;
      cfg.max_duty    <= adcs_pkg::RST_MAX_DUTY;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        adcs_pkg::REG_BUS_GAIN:   cfg.bus_gain    <= cfg_wdata;
        adcs_pkg::REG_PWM_PERIOD: cfg.pwm_period  <= cfg_wdata;
        adcs_pkg::REG_MIN_DUTY:   cfg.min_duty    <= cfg_wdata;
        adcs_pkg::REG_MAX_DUTY:   cfg.max_duty    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  adcs_scan #(
    .VBUS_AVG_LOG2 (VBUS_AVG_LOG2),
    .POT_AVG_LOG2  (POT_AVG_LOG2),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .sample_main (s_axis_tdata[9:0]),
    .rec_valid   (rec_valid),
    .rec_ready   (rec_ready),
    .rec         (rec)
  );

  adcs_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {7'd0, res.aux_sample, res.pot_duty, res.bus_voltage,
                         res.pot_average, res.vbus_average, res.next_channel};
  assign m_axis_tuser = {res.pot_updated, res.vbus_updated, res.scanned_channel};

endmodule

>>> hdl/adcs_scan.sv
// ----------------------------------------------------------------------------
// adcs_scan: channel rotation and block averaging
// Takes one conversion word per cycle unless held off, advances the scan phase,
// accumulates bus and knob samples and registers the averages seen after it.
// ----------------------------------------------------------------------------
module adcs_scan #(
  parameter int VBUS_AVG_LOG2 = 6,
  parameter int POT_AVG_LOG2  = 3,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          sample_main,
  output logic                rec_valid,
  input  logic                rec_ready,
  output adcs_pkg::scan_rec_t rec
);

  localparam int VSUM_W = SAMPLE_BITS + VBUS_AVG_LOG2;
  localparam int PSUM_W = SAMPLE_BITS + POT_AVG_LOG2;

  adcs_pkg::scan_phase_t   phase, phase_next;
  logic [VSUM_W-1:0]        vbus_sum, vbus_sum_next, vbus_sum_add;
  logic [VBUS_AVG_LOG2-1:0] vbus_count, vbus_count_next;
  logic [SAMPLE_BITS-1:0]   vbus_avg, vbus_avg_next;
  logic [PSUM_W-1:0]        pot_sum, pot_sum_next, pot_sum_add;
  logic [POT_AVG_LOG2-1:0]  pot_count, pot_count_next;
  logic [SAMPLE_BITS-1:0]   pot_avg, pot_avg_next;
  logic [SAMPLE_BITS-1:0]   aux, aux_next;
  logic [SAMPLE_BITS-1:0]   s;
  logic                     vupd, pupd;
  logic [adcs_pkg::CH_W-1:0] scanned, next_ch;
  logic                     fire;

  assign in_ready = !rec_valid || rec_ready;
  assign fire     = in_valid && in_ready;
  assign s        = SAMPLE_BITS'(sample_main);

  assign vbus_sum_add = vbus_sum + VSUM_W'(s);
  assign pot_sum_add  = pot_sum + PSUM_W'(s);

  always_comb begin
    phase_next      = phase;
    vbus_sum_next   = vbus_sum;
    vbus_count_next = vbus_count;
    vbus_avg_next   = vbus_avg;
    pot_sum_next    = pot_sum;
    pot_count_next  = pot_count;
    pot_avg_next    = pot_avg;
    aux_next        = aux;
    vupd            = 1'b0;
    pupd            = 1'b0;
    scanned         = adcs_pkg::CH_BUS;
    next_ch         = adcs_pkg::CH_POT;
    unique case (phase)
      adcs_pkg::PH_BUS: begin
        phase_next = adcs_pkg::PH_POT;
        // The block closes on the sample that brings the count to a full block.
        if (&vbus_count) begin
          vbus_avg_next   = SAMPLE_BITS'(vbus_sum_add >> VBUS_AVG_LOG2);
          vbus_sum_next   = '0;
          vbus_count_next = '0;
          vupd            = 1'b1;
        end else begin
          vbus_sum_next   = vbus_sum_add;
          vbus_count_next = vbus_count + VBUS_AVG_LOG2'(1);
        end
      end
      adcs_pkg::PH_POT: begin
        scanned    = adcs_pkg::CH_POT;
        next_ch    = adcs_pkg::CH_AUX;
        phase_next = adcs_pkg::PH_AUX;
        if (&pot_count) begin
          pot_avg_next   = SAMPLE_BITS'(pot_sum_add >> POT_AVG_LOG2);
          pot_sum_next   = '0;
          pot_count_next = '0;
          pupd           = 1'b1;
        end else begin
          pot_sum_next   = pot_sum_add;
          pot_count_next = pot_count + POT_AVG_LOG2'(1);
        end
      end
      adcs_pkg::PH_AUX: begin
        scanned    = adcs_pkg::CH_AUX;
        next_ch    = adcs_pkg::CH_BUS;
        phase_next = adcs_pkg::PH_BUS;
        aux_next   = s;
      end
      default: begin
        // Start phase: the first bus word is reported but not accumulated.
        phase_next = adcs_pkg::PH_POT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= adcs_pkg::PH_START;
      vbus_sum   <= '0;
      vbus_count <= '0;
      vbus_avg   <= '0;
      pot_sum    <= '0;
      pot_count  <= '0;
      pot_avg    <= '0;
      aux        <= '0;
      rec_valid  <= 1'b0;
    end else begin
      if (fire) begin
        phase      <= phase_next;
        vbus_sum   <= vbus_sum_next;
        vbus_count <= vbus_count_next;
        vbus_avg   <= vbus_avg_next;
        pot_sum    <= pot_sum_next;
        pot_count  <= pot_count_next;
        pot_avg    <= pot_avg_next;
        aux        <= aux_next;
      end
      if (in_ready) begin
        rec_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rec.scanned_channel <= scanned;
      rec.next_channel    <= next_ch;
      rec.vbus_avg        <= adcs_pkg::AVG_W'(vbus_avg_next);
      rec.pot_avg         <= adcs_pkg::AVG_W'(pot_avg_next);
      rec.vbus_updated    <= vupd;
      rec.pot_updated     <= pupd;
      rec.aux             <= adcs_pkg::AVG_W'(aux_next);
    end
  end

endmodule

>>> hdl/adcs_scale.sv
// ----------------------------------------------------------------------------
// adcs_scale: bus voltage scaling and knob duty computation
// One stage multiplies both averages by their factors, the next applies the
// duty limits and holds the finished result until it is taken.
// ----------------------------------------------------------------------------
module adcs_scale #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  adcs_pkg::cfg_t      cfg,
  input  logic                rec_valid,
  output logic                rec_ready,
  input  adcs_pkg::scan_rec_t rec,
  output logic                res_valid,
  input  logic                res_ready,
  output adcs_pkg::result_t   res
);

  localparam int RW     = adcs_pkg::REG_W;
  localparam int BV_W   = RW + adcs_pkg::AVG_W;
  localparam int DUTY_P = 2 * RW;

  logic [BV_W-1:0]   bv_prod;
  logic [RW-1:0]     pot_norm;
  logic [DUTY_P-1:0] duty_prod;

  logic                mul_valid;
  adcs_pkg::scan_rec_t mul_rec;
  logic [RW-1:0]       mul_bus_voltage;
  logic [RW-1:0]       mul_duty_raw;
  logic [RW-1:0]       duty_limited;

  logic res_load, mul_load;

  assign res_load  = !res_valid || res_ready;
  assign mul_load  = !mul_valid || res_load;
  assign rec_ready = mul_load;

  assign bv_prod   = BV_W'(cfg.bus_gain) * BV_W'(rec.vbus_avg);
  // Normalise the knob average to a 16-bit full scale before scaling.
  assign pot_norm  = RW'(32'(rec.pot_avg) << (RW - SAMPLE_BITS));
  assign duty_prod = DUTY_P'(pot_norm) * DUTY_P'(cfg.pwm_period);

  always_comb begin
    if (mul_duty_raw < cfg.min_duty) begin
      duty_limited = '0;
    end else if (mul_duty_raw > cfg.max_duty) begin
      duty_limited = cfg.max_duty;
    end else begin
      duty_limited = mul_duty_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (mul_load) begin
        mul_valid <= rec_valid;
      end
      if (res_load) begin
        res_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_load && rec_valid) begin
      mul_rec         <= rec;
      mul_bus_voltage <= RW'(bv_prod >> adcs_pkg::BUS_SHIFT);
      mul_duty_raw    <= duty_prod[DUTY_P-1:RW];
    end
    if (res_load && mul_valid) begin
      res.scanned_channel <= mul_rec.scanned_channel;
      res.next_channel    <= mul_rec.next_channel;
      res.vbus_average    <= adcs_pkg::OUT_W'(mul_rec.vbus_avg);
      res.pot_average     <= adcs_pkg::OUT_W'(mul_rec.pot_avg);
      res.vbus_updated    <= mul_rec.vbus_updated;
      res.pot_updated     <= mul_rec.pot_updated;
      res.bus_voltage     <= mul_bus_voltage;
      res.pot_duty        <= duty_limited;
      res.aux_sample      <= adcs_pkg::OUT_W'(mul_rec.aux);
    end
  end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for adc_scan_average_scale
// Feeds conversion words through the sample stream with random gaps and
// output stalls, predicts each result word from its own model of the scan,
// the block averages and the scaling, and compares every field in order.
// Register settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam int VBUS_AVG_LOG2 = 6;
  localparam int POT_AVG_LOG2  = 3;
  localparam int SAMPLE_BITS   = 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 40;

  // Sample generation styles.
  localparam int GEN_UNIFORM = 0;
  localparam int GEN_EXTREME = 1;
  localparam int GEN_FULL    = 2;
  localparam int GEN_LOW     = 3;
  localparam int GEN_HIGH    = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [9:0] sample_main
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [2:0] next_channel, [12:3] vbus_average, [22:13] pot_average,
  // [38:23] bus_voltage, [54:39] pot_duty, [64:55] aux_sample
  logic [71:0] m_axis_tdata;
  // [2:0] scanned_channel, [3] vbus_updated, [4] pot_updated
  logic [4:0]  m_axis_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  adc_scan_average_scale #(
    .VBUS_AVG_LOG2(VBUS_AVG_LOG2),
    .POT_AVG_LOG2 (POT_AVG_LOG2),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state; sums and averages are kept at the block's widths.
  adcs_pkg::cfg_t             cur_cfg;
  adcs_pkg::scan_phase_t      scan_state;
  logic [15:0]                vbus_sum;
  int                         vbus_count;
  logic [adcs_pkg::OUT_W-1:0] vbus_avg;
  logic [12:0]                pot_sum;
  int                         pot_count;
  logic [adcs_pkg::OUT_W-1:0] pot_avg;
  logic [adcs_pkg::OUT_W-1:0] aux_last;

  logic [9:0]        sample_queue[$];
  adcs_pkg::result_t pending_results[$];

  int  words_queued   = 0;
  int  words_accepted = 0;
  int  words_checked  = 0;
  int  bus_blocks     = 0;
  int  pot_blocks     = 0;
  int  reg_writes     = 0;
  int  settings_run   = 0;
  int  error_count    = 0;
  int  cycle_count    = 0;
  bit  calm           = 1'b0;
  int  src_gap;
  int  sink_stall;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [9:0] gen_sample(input int style);
    case (style)
      GEN_EXTREME: return $urandom_range(0, 1) ? 10'h3FF : 10'h000;
      GEN_FULL:    return 10'h3FF;
      GEN_LOW:     return 10'($urandom_range(0, 7));
      GEN_HIGH:    return 10'($urandom_range(1016, 1023));
      default:     return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // One accepted conversion word: advance the scan and work out its result.
  task automatic scan_step(input logic [9:0] sample);
    adcs_pkg::result_t res;
    logic [31:0]       bus_prod;
    logic [15:0]       scaled_pot;
    logic [31:0]       duty_prod;
    logic [15:0]       duty_raw;
    res = '0;
    case (scan_state)
      adcs_pkg::PH_BUS: begin
        res.scanned_channel = adcs_pkg::CH_BUS;
        res.next_channel = adcs_pkg::CH_POT;
        vbus_sum = vbus_sum + 16'(sample);
        vbus_count++;
        if (vbus_count >= (1 << VBUS_AVG_LOG2)) begin
          vbus_avg = adcs_pkg::OUT_W'(vbus_sum >> VBUS_AVG_LOG2);
          vbus_sum = '0;
          vbus_count = 0;
          res.vbus_updated = 1'b1;
          bus_blocks++;
        end
        scan_state = adcs_pkg::PH_POT;
      end
      adcs_pkg::PH_POT: begin
        res.scanned_channel = adcs_pkg::CH_POT;
        res.next_channel = adcs_pkg::CH_AUX;
        pot_sum = pot_sum + 13'(sample);
        pot_count++;
        if (pot_count >= (1 << POT_AVG_LOG2)) begin
          pot_avg = adcs_pkg::OUT_W'(pot_sum >> POT_AVG_LOG2);
          pot_sum = '0;
          pot_count = 0;
          res.pot_updated = 1'b1;
          pot_blocks++;
        end
        scan_state = adcs_pkg::PH_AUX;
      end
      adcs_pkg::PH_AUX: begin
        res.scanned_channel = adcs_pkg::CH_AUX;
        res.next_channel = adcs_pkg::CH_BUS;
        aux_last = sample;
        scan_state = adcs_pkg::PH_BUS;
      end
      default: begin
        // The first word after reset counts as a bus word but is not summed.
        res.scanned_channel = adcs_pkg::CH_BUS;
        res.next_channel = adcs_pkg::CH_POT;
        scan_state = adcs_pkg::PH_POT;
      end
    endcase

    bus_prod = 32'(cur_cfg.bus_gain) * 32'(vbus_avg);
    scaled_pot = 16'(32'(pot_avg) << (16 - SAMPLE_BITS));
    duty_prod = 32'(scaled_pot) * 32'(cur_cfg.pwm_period);
    duty_raw = duty_prod[31:16];

    res.vbus_average = vbus_avg;
    res.pot_average = pot_avg;
    res.bus_voltage = 16'(bus_prod >> adcs_pkg::BUS_SHIFT);
    if (duty_raw < cur_cfg.min_duty)
      res.pot_duty = '0;
    else
      res.pot_duty = (duty_raw > cur_cfg.max_duty) ? cur_cfg.max_duty : duty_raw;
    res.aux_sample = aux_last;
    pending_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch at result word %0d: %s", words_checked, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Sample stream driver.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
      scan_state = adcs_pkg::PH_START;
      vbus_sum = '0;
      vbus_count = 0;
      vbus_avg = '0;
      pot_sum = '0;
      pot_count = 0;
      pot_avg = '0;
      aux_last = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        scan_step(s_axis_tdata[9:0]);
        words_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          s_axis_tdata <= {6'b0, sample_queue.pop_front()};
          s_axis_tvalid <= 1'b1;
          src_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result stream back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      sink_stall = pick_gap();
      m_axis_tready <= (sink_stall == 0);
      if (sink_stall > 0) sink_stall--;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    adcs_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with no expectation waiting");
      end else begin
        want = pending_results.pop_front();
        check_field("scanned_channel", 16'(m_axis_tuser[2:0]), 16'(want.scanned_channel));
        check_field("vbus_updated", 16'(m_axis_tuser[3]), 16'(want.vbus_updated));
        check_field("pot_updated", 16'(m_axis_tuser[4]), 16'(want.pot_updated));
        check_field("next_channel", 16'(m_axis_tdata[2:0]), 16'(want.next_channel));
        check_field("vbus_average", 16'(m_axis_tdata[12:3]), 16'(want.vbus_average));
        check_field("pot_average", 16'(m_axis_tdata[22:13]), 16'(want.pot_average));
        check_field("bus_voltage", m_axis_tdata[38:23], want.bus_voltage);
        check_field("pot_duty", m_axis_tdata[54:39], want.pot_duty);
        check_field("aux_sample", 16'(m_axis_tdata[64:55]), 16'(want.aux_sample));
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [adcs_pkg::IDX_W-1:0] idx,
                           input logic [adcs_pkg::REG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      adcs_pkg::REG_BUS_GAIN:   cur_cfg.bus_gain = value;
      adcs_pkg::REG_PWM_PERIOD: cur_cfg.pwm_period = value;
      adcs_pkg::REG_MIN_DUTY:   cur_cfg.min_duty = value;
      adcs_pkg::REG_MAX_DUTY:   cur_cfg.max_duty = value;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] gain, input logic [15:0] period,
                            input logic [15:0] lo, input logic [15:0] hi);
    write_reg(adcs_pkg::REG_BUS_GAIN, gain);
    write_reg(adcs_pkg::REG_PWM_PERIOD, period);
    write_reg(adcs_pkg::REG_MIN_DUTY, lo);
    write_reg(adcs_pkg::REG_MAX_DUTY, hi);
    settings_run++;
  endtask

  task automatic push_sample(input logic [9:0] sample);
    sample_queue.push_back(sample);
    words_queued++;
  endtask

  task automatic run_random(input int count, input int style);
    for (int i = 0; i < count; i++) push_sample(gen_sample(style));
    while (words_accepted != words_queued || pending_results.size() != 0)
      @(posedge clk);
  endtask

  logic [9:0] patterns[6] = '{10'h000, 10'h155, 10'h2AA, 10'h3FF, 10'h001, 10'h200};

  initial begin
    logic [15:0] lo;
    cur_cfg.bus_gain = adcs_pkg::RST_BUS_GAIN;
    cur_cfg.pwm_period = adcs_pkg::RST_PWM_PERIOD;
    cur_cfg.min_duty = adcs_pkg::RST_MIN_DUTY;
    cur_cfg.max_duty = adcs_pkg::RST_MAX_DUTY;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset settings: the first word lands in the
    // start phase, knob words are all full scale, the rest walk bit patterns.
    settings_run++;
    for (int i = 0; i < 24; i++)
      push_sample((i % 3 == 1) ? 10'h3FF : patterns[i % 6]);
    run_random(0, GEN_UNIFORM);

    // Full-scale words long enough to complete whole bus and knob blocks.
    set_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    run_random(200, GEN_FULL);

    calm = 1'b1;
    set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(80, GEN_EXTREME);
    calm = 1'b0;

    // Minimum above maximum.
    lo = 16'($urandom_range(1000, 65535));
    set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), lo,
               16'($urandom_range(0, lo - 1)));
    run_random(80, GEN_UNIFORM);

    set_config(16'($urandom_range(0, 65535)), 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(80, GEN_HIGH);

    calm = ($urandom_range(0, 1) == 1);
    set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 3000)), 16'($urandom_range(3000, 65535)));
    run_random(80, GEN_LOW);
    calm = 1'b0;

    set_config(16'($urandom_range(0, 65535)), adcs_pkg::RST_PWM_PERIOD,
               16'($urandom_range(0, 2000)), 16'($urandom_range(2000, 6000)));
    run_random(80, GEN_UNIFORM);

    repeat (10) @(posedge clk);
    $display("Checked %0d result words from %0d samples under %0d register settings",
             words_checked, words_accepted, settings_run);
    $display("(%0d register writes); %0d bus and %0d knob averages completed.",
             reg_writes, bus_blocks, pot_blocks);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               error_count, pending_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/adcs_pkg.sv
hdl/adcs_scan.sv
hdl/adcs_scale.sv
hdl/adc_scan_average_scale.sv
tb/sv/testbench.sv
